/* hw/rtl/rbsc_pkg.sv */
// Shared constants, command codes and control types for the relay bank.
package rbsc_pkg;

  localparam int OUTPUT_COUNT = 160;
  localparam int BLOCK_BYTES  = 4;

  localparam int NBYTES     = (OUTPUT_COUNT + 7) / 8;
  localparam int NBLOCKS    = (NBYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int BLOCK_BITS = 8 * BLOCK_BYTES;
  localparam int PAD_BITS   = NBLOCKS * BLOCK_BITS;
  localparam int ADDR_W     = $clog2(OUTPUT_COUNT);
  localparam int BLK_W      = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
  localparam int BIT_W      = $clog2(BLOCK_BITS);
  localparam int FLAGS_SHOWN = 8;

  localparam logic [3:0] KIND_ONE_ON     = 4'd0;
  localparam logic [3:0] KIND_ONE_OFF    = 4'd1;
  localparam logic [3:0] KIND_BLK_TOGGLE = 4'd2;
  localparam logic [3:0] KIND_BLK_ON     = 4'd3;
  localparam logic [3:0] KIND_BLK_OFF    = 4'd4;
  localparam logic [3:0] KIND_CNT_READ   = 4'd5;
  localparam logic [3:0] KIND_CNT_WRITE  = 4'd6;
  localparam logic [3:0] KIND_CLEAR      = 4'd7;
  localparam logic [3:0] KIND_ACK        = 4'd8;

  // Bits that map onto real relays; padding bits stay zero.
  function automatic logic [PAD_BITS-1:0] relay_valid_mask();
    logic [PAD_BITS-1:0] v;
    for (int i = 0; i < PAD_BITS; i++) begin
      v[i] = (i < OUTPUT_COUNT);
    end
    return v;
  endfunction

  localparam logic [PAD_BITS-1:0] RELAY_VALID = relay_valid_mask();

  typedef struct packed {
    logic             load;
    logic             exec;
    logic             scan;
    logic [BIT_W-1:0] bit_idx;
    logic             emit;
  } rbsc_cmd_t;

  typedef struct packed {
    logic commit;
  } rbsc_status_t;

endpackage

/* hw/rtl/rbsc_ctrl.sv */
// Command sequencer: decode, counter scan over the touched block, result issue.
module rbsc_ctrl
  import rbsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  rbsc_status_t status,
  output rbsc_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [BIT_W-1:0] bit_cnt;

  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BLOCK_BITS - 1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_EXEC;
      ST_EXEC:   state_next = status.commit ? ST_SCAN : ST_FINISH;
      ST_SCAN:   if (bit_cnt == LAST_BIT) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
      busy    <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
      if (state == ST_SCAN) begin
        bit_cnt <= bit_cnt + 1'b1;
      end else begin
        bit_cnt <= '0;
      end
    end
  end

  always_comb begin
    cmd.load    = (state == ST_IDLE) && start;
    cmd.exec    = (state == ST_EXEC);
    cmd.scan    = (state == ST_SCAN);
    cmd.bit_idx = bit_cnt;
    cmd.emit    = (state == ST_FINISH);
  end

endmodule

/* hw/rtl/rbsc_datapath.sv */
// Relay bits, changed flags, switch counter memory and result registers.
module rbsc_datapath
  import rbsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  rbsc_cmd_t    cmd,
  output rbsc_status_t status,
  input  logic [3:0]   kind,
  input  logic [7:0]   relay_sel,
  input  logic [2:0]   block_index,
  input  logic [31:0]  block_mask,
  input  logic [31:0]  count_value,
  output logic         done,
  output logic [31:0]  count_out,
  output logic [31:0]  block_state,
  output logic [7:0]   changed_blocks,
  output logic         index_error
);

  // Latched command
  logic [3:0]  k_q;
  logic [7:0]  r_q;
  logic [2:0]  b_q;
  logic [31:0] m_q;
  logic [31:0] v_q;

  logic [PAD_BITS-1:0] relay;
  logic [NBLOCKS-1:0]  flags;

  logic [31:0]       mem [OUTPUT_COUNT];
  logic [OUTPUT_COUNT-1:0] cnt_valid;
  logic [31:0]       rdata;
  logic              rvalid;

  logic [BLOCK_BITS-1:0] rise_q;
  logic [BLK_W-1:0]      scan_blk;
  logic                  pend;
  logic [ADDR_W-1:0]     pend_addr;
  logic                  res_read;

  // Decode
  logic                  relay_kind;
  logic                  block_kind;
  logic                  err;
  logic                  commit_go;
  logic                  shown_ok;
  logic [BLK_W-1:0]      relay_blk;
  logic [BIT_W-1:0]      relay_off;
  logic [BLK_W-1:0]      sel_blk;
  int                    base;
  logic [BLOCK_BITS-1:0] cur;
  logic [BLOCK_BITS-1:0] vmask;
  logic [BLOCK_BITS-1:0] m;
  logic [BLOCK_BITS-1:0] onebit;
  logic [BLOCK_BITS-1:0] tog;
  logic [BLOCK_BITS-1:0] new_word;
  logic [BLOCK_BITS-1:0] after_word;
  logic [NBLOCKS-1:0]    flags_after;

  // Memory ports
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic [ADDR_W-1:0] scan_addr;
  logic [31:0]       eff;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_q <= kind;
      r_q <= relay_sel;
      b_q <= block_index;
      m_q <= block_mask;
      v_q <= count_value;
    end
  end

  always_comb begin
    relay_kind = (k_q == KIND_ONE_ON) || (k_q == KIND_ONE_OFF) ||
                 (k_q == KIND_CNT_READ) || (k_q == KIND_CNT_WRITE);
    block_kind = (k_q == KIND_BLK_TOGGLE) || (k_q == KIND_BLK_ON) ||
                 (k_q == KIND_BLK_OFF);

    // Block holding the relay: independent threshold compares
    relay_blk = '0;
    for (int k = 1; k < NBLOCKS; k++) begin
      if (int'(r_q) >= k * BLOCK_BITS) relay_blk = BLK_W'(k);
    end
    relay_off = BIT_W'(int'(r_q) - int'(relay_blk) * BLOCK_BITS);

    err = 1'b0;
    if (relay_kind && int'(r_q) >= OUTPUT_COUNT) err = 1'b1;
    if (block_kind && int'(b_q) >= NBLOCKS) err = 1'b1;
    commit_go = (k_q <= KIND_BLK_OFF) && !err;

    sel_blk  = relay_kind ? relay_blk : BLK_W'(b_q);
    shown_ok = relay_kind || (int'(b_q) < NBLOCKS);
    base     = int'(sel_blk) * BLOCK_BITS;
    cur      = relay[base +: BLOCK_BITS];
    vmask    = RELAY_VALID[base +: BLOCK_BITS];
    m        = m_q[BLOCK_BITS-1:0] & vmask;
    onebit   = BLOCK_BITS'(1) << relay_off;

    // Per-byte toggle: overlap clears the masked bits, otherwise sets them
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (m[8*i +: 8] == 8'd0) begin
        tog[8*i +: 8] = cur[8*i +: 8];
      end else if ((m[8*i +: 8] & cur[8*i +: 8]) == 8'd0) begin
        tog[8*i +: 8] = cur[8*i +: 8] | m[8*i +: 8];
      end else begin
        tog[8*i +: 8] = cur[8*i +: 8] & ~m[8*i +: 8];
      end
    end

    case (k_q)
      KIND_ONE_ON:     new_word = cur | onebit;
      KIND_ONE_OFF:    new_word = cur & ~onebit;
      KIND_BLK_TOGGLE: new_word = tog;
      KIND_BLK_ON:     new_word = cur | m;
      KIND_BLK_OFF:    new_word = cur & ~m;
      default:         new_word = cur;
    endcase

    if (err || !shown_ok) begin
      after_word = '0;
    end else if (k_q == KIND_CLEAR) begin
      after_word = '0;
    end else begin
      after_word = new_word;
    end

    flags_after = flags;
    if (commit_go && (new_word != cur)) flags_after[sel_blk] = 1'b1;
  end

  assign status.commit = commit_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      relay <= '0;
      flags <= '0;
    end else if (cmd.exec) begin
      if (commit_go) begin
        relay[base +: BLOCK_BITS] <= new_word;
        flags <= flags_after;
      end
      if (k_q == KIND_CLEAR) relay <= '0;
      if (k_q == KIND_ACK) flags <= '0;
    end
  end

  // Result fields other than the count settle at execute and hold
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rise_q      <= commit_go ? (new_word & ~cur) : '0;
      scan_blk    <= sel_blk;
      res_read    <= (k_q == KIND_CNT_READ) && !err;
      index_error <= err;
      block_state <= 32'(after_word);
      for (int i = 0; i < FLAGS_SHOWN; i++) begin
        changed_blocks[i] <= (i < NBLOCKS) ? flags_after[i % NBLOCKS] : 1'b0;
      end
    end
  end

  // Counter memory: read one rising relay per scan step, write its increment next cycle
  assign scan_addr = ADDR_W'(int'(scan_blk) * BLOCK_BITS + int'(cmd.bit_idx));
  assign eff       = rvalid ? rdata : 32'd0;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_addr;
    if (cmd.exec && (k_q == KIND_CNT_READ) && !err) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(r_q);
    end else if (cmd.scan && rise_q[cmd.bit_idx]) begin
      rd_en = 1'b1;
    end

    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = eff + 32'd1;
    if (pend) begin
      wr_en = 1'b1;
    end else if (cmd.exec && (k_q == KIND_CNT_WRITE) && !err) begin
      wr_en   = 1'b1;
      wr_addr = ADDR_W'(r_q);
      wr_data = v_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rdata  <= mem[rd_addr];
      rvalid <= cnt_valid[rd_addr];
    end
    pend_addr <= scan_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
      pend      <= 1'b0;
    end else begin
      if (wr_en) cnt_valid[wr_addr] <= 1'b1;
      pend <= cmd.scan && rise_q[cmd.bit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) count_out <= res_read ? eff : 32'd0;
  end

endmodule

/* hw/rtl/relay_bank_with_switch_counters_unit.sv */
// Relay bank with per-relay switch-on counters and sticky changed-block flags.
// A command is taken when start is high and busy is low; one result follows on done.
// Flow: the command executes; a switching command that commits then scans the addressed
// block's counters, one relay a cycle; then the result is issued and done is registered.
// Commands are taken one at a time, not before busy falls; done cannot be held off.
// Synchronous reset clears relays, changed flags and counter valid bits at once.
module relay_bank_with_switch_counters_unit
  import rbsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  kind,
  input  logic [7:0]  relay_sel,
  input  logic [2:0]  block_index,
  input  logic [31:0] block_mask,
  input  logic [31:0] count_value,
  output logic        done,
  output logic [31:0] count_out,
  output logic [31:0] block_state,
  output logic [7:0]  changed_blocks,
  output logic        index_error
);

  rbsc_cmd_t    cmd;
  rbsc_status_t status;

  rbsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  rbsc_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .kind           (kind),
    .relay_sel      (relay_sel),
    .block_index    (block_index),
    .block_mask     (block_mask),
    .count_value    (count_value),
    .done           (done),
    .count_out      (count_out),
    .block_state    (block_state),
    .changed_blocks (changed_blocks),
    .index_error    (index_error)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result issued while a command is still in progress");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a command transfer");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && index_error) |-> (count_out == 32'd0 && block_state == 32'd0))
    else $error("rejected command returned nonzero data");

endmodule

/* verif/tb.sv */
// Testbench for the relay bank: directed and random commands checked against a local model.
`timescale 1ns / 100ps

module tb;
  import rbsc_pkg::*;

  localparam logic [3:0] KIND_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] KIND_LAST_UNUSED  = 4'd15;
  localparam int         RANDOM_COMMANDS   = 1025;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  relay;
    logic [2:0]  blk;
    logic [31:0] mask;
    logic [31:0] value;
    bit          hold;
  } relay_cmd_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] state;
    logic [7:0]  flags;
    logic        err;
  } relay_result_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        start       = 1'b0;
  logic [3:0]  kind        = '0;
  logic [7:0]  relay_sel   = '0;
  logic [2:0]  block_index = '0;
  logic [31:0] block_mask  = '0;
  logic [31:0] count_value = '0;
  logic        busy;
  logic        done;
  logic [31:0] count_out;
  logic [31:0] block_state;
  logic [7:0]  changed_blocks;
  logic        index_error;

  // Local copy of the bank state
  logic [7:0]  relay_bytes [NBYTES]       = '{default: '0};
  logic [31:0] switch_tally [OUTPUT_COUNT] = '{default: '0};
  bit          block_dirty [NBLOCKS]       = '{default: 1'b0};

  relay_cmd_t    cmd_q[$];
  relay_result_t expected_q[$];
  relay_cmd_t    cur_cmd;
  int            n_issued = 0;
  int            n_done   = 0;
  int            n_sent   = 0;
  int            n_errors = 0;

  relay_bank_with_switch_counters_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .relay_sel      (relay_sel),
    .block_index    (block_index),
    .block_mask     (block_mask),
    .count_value    (count_value),
    .done           (done),
    .count_out      (count_out),
    .block_state    (block_state),
    .changed_blocks (changed_blocks),
    .index_error    (index_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Apply one command to the local state and return the result it should give.
  function automatic relay_result_t apply_command(input relay_cmd_t c);
    logic [7:0]    prior [NBYTES];
    logic [7:0]    m;
    logic [7:0]    rise;
    relay_result_t r;
    int            shown;
    int            b;
    bit            err;
    bit            relay_kind;
    bit            block_kind;
    prior = relay_bytes;
    r = '0;
    err = 1'b0;
    shown = c.blk;
    relay_kind = (c.kind == KIND_ONE_ON || c.kind == KIND_ONE_OFF ||
                  c.kind == KIND_CNT_READ || c.kind == KIND_CNT_WRITE);
    block_kind = (c.kind == KIND_BLK_TOGGLE || c.kind == KIND_BLK_ON ||
                  c.kind == KIND_BLK_OFF);
    if (relay_kind) begin
      shown = c.relay / BLOCK_BITS;
      err = (c.relay >= OUTPUT_COUNT);
    end
    if (block_kind && c.blk >= NBLOCKS) err = 1'b1;

    if (!err) begin
      case (c.kind)
        KIND_ONE_ON:  relay_bytes[c.relay / 8][c.relay % 8] = 1'b1;
        KIND_ONE_OFF: relay_bytes[c.relay / 8][c.relay % 8] = 1'b0;
        KIND_BLK_TOGGLE, KIND_BLK_ON, KIND_BLK_OFF: begin
          for (int i = 0; i < BLOCK_BYTES && i < 4; i++) begin
            b = c.blk * BLOCK_BYTES + i;
            if (b < NBYTES) begin
              m = c.mask[8*i +: 8];
              for (int j = 0; j < 8; j++) begin
                if (8*b + j >= OUTPUT_COUNT) m[j] = 1'b0;
              end
              // toggle clears the masked bits of a byte whose mask overlaps it, else sets them
              if (c.kind == KIND_BLK_ON ||
                  (c.kind == KIND_BLK_TOGGLE && m != 0 && (m & relay_bytes[b]) == 0))
                relay_bytes[b] = relay_bytes[b] | m;
              else if (c.kind == KIND_BLK_OFF || (c.kind == KIND_BLK_TOGGLE && m != 0))
                relay_bytes[b] = relay_bytes[b] & ~m;
            end
          end
        end
        KIND_CNT_READ:  r.count = switch_tally[c.relay];
        KIND_CNT_WRITE: switch_tally[c.relay] = c.value;
        KIND_CLEAR: begin
          for (b = 0; b < NBYTES; b++) relay_bytes[b] = '0;
          prior = relay_bytes;
        end
        default: ;
      endcase
    end

    // count rising edges and mark changed blocks for switching commands
    if (c.kind <= KIND_BLK_OFF) begin
      for (b = 0; b < NBYTES; b++) begin
        rise = relay_bytes[b] & ~prior[b];
        if (relay_bytes[b] != prior[b]) block_dirty[b / BLOCK_BYTES] = 1'b1;
        for (int j = 0; j < 8; j++) begin
          if (rise[j] && 8*b + j < OUTPUT_COUNT)
            switch_tally[8*b + j] = switch_tally[8*b + j] + 32'd1;
        end
      end
    end

    for (int i = 0; i < NBLOCKS && i < 8; i++) r.flags[i] = block_dirty[i];
    if (c.kind == KIND_ACK) begin
      for (int i = 0; i < NBLOCKS; i++) block_dirty[i] = 1'b0;
    end

    if (!err && shown < NBLOCKS) begin
      for (int i = 0; i < BLOCK_BYTES && i < 4; i++) begin
        b = shown * BLOCK_BYTES + i;
        if (b < NBYTES) r.state[8*i +: 8] = relay_bytes[b];
      end
    end
    r.err = err;
    return r;
  endfunction

  task automatic push_command(input logic [3:0] k, input logic [7:0] rl, input logic [2:0] bl,
                              input logic [31:0] mk, input logic [31:0] vl, input bit hd);
    relay_cmd_t c;
    c.kind = k;
    c.relay = rl;
    c.blk = bl;
    c.mask = mk;
    c.value = vl;
    c.hold = hd;
    cmd_q.push_back(c);
  endtask

  function automatic relay_cmd_t random_command();
    relay_cmd_t c;
    int         roll;
    c.relay = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, OUTPUT_COUNT - 1));
    c.blk = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7))
                                        : 3'($urandom_range(0, NBLOCKS - 1));
    case ($urandom_range(0, 4))
      0:       c.mask = 32'hFF << (8 * $urandom_range(0, 3));
      1:       c.mask = 32'h1 << $urandom_range(0, 31);
      2:       c.mask = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      default: c.mask = $urandom;
    endcase
    // writes near the top let later switch-ons wrap the counter
    c.value = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3);
    c.hold = 1'b0;
    roll = $urandom_range(0, 99);
    if (roll < 15)      c.kind = KIND_ONE_ON;
    else if (roll < 25) c.kind = KIND_ONE_OFF;
    else if (roll < 40) c.kind = KIND_BLK_TOGGLE;
    else if (roll < 53) c.kind = KIND_BLK_ON;
    else if (roll < 63) c.kind = KIND_BLK_OFF;
    else if (roll < 73) c.kind = KIND_CNT_READ;
    else if (roll < 81) c.kind = KIND_CNT_WRITE;
    else if (roll < 85) c.kind = KIND_CLEAR;
    else if (roll < 95) c.kind = KIND_ACK;
    else                c.kind = 4'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
    return c;
  endfunction

  // Driver: present queued commands, hold each until its transfer.
  always @(posedge clk) begin : drive
    bit quiet;
    bit stall;
    if (!rst) begin
      if (start && !busy) begin
        expected_q.push_back(apply_command(cur_cmd));
        n_issued++;
      end
      quiet = (n_sent >= 400 && n_sent < 650);
      if (start && busy) begin
        // hold the current command
      end else begin
        stall = cmd_q.size() == 0 ||
                (cmd_q[0].hold && n_issued != n_done + done) ||
                (!quiet && $urandom_range(0, 99) < 25);
        if (!stall) begin
          cur_cmd = cmd_q.pop_front();
          n_sent++;
          kind <= cur_cmd.kind;
          relay_sel <= cur_cmd.relay;
          block_index <= cur_cmd.blk;
          block_mask <= cur_cmd.mask;
          count_value <= cur_cmd.value;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin : watch
    relay_result_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result: count %h state %h flags %h err %b",
                                     count_out, block_state, changed_blocks, index_error);
      end else begin
        want = expected_q.pop_front();
        if (count_out !== want.count || block_state !== want.state ||
            changed_blocks !== want.flags || index_error !== want.err) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: count %h/%h state %h/%h flags %h/%h err %b/%b (exp/act)",
                     want.count, count_out, want.state, block_state,
                     want.flags, changed_blocks, want.err, index_error);
        end
      end
      n_done <= n_done + 1;
    end
  end

  initial begin : stimulus
    relay_cmd_t c;
    int         n_real;
    n_real = 0;
    push_command(KIND_CNT_READ,   8'd0,   3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_CNT_WRITE,  8'd0,   3'd0, 32'h0,         32'hFFFF_FFFF, 1'b0);
    push_command(KIND_ONE_ON,     8'd0,   3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_CNT_READ,   8'd0,   3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_ONE_ON,     8'd159, 3'd7, 32'hFFFF_FFFF, 32'h0,         1'b0);
    push_command(KIND_ONE_OFF,    8'd159, 3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_ONE_ON,     8'd160, 3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_ONE_OFF,    8'd255, 3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_CNT_READ,   8'd255, 3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_CNT_WRITE,  8'd200, 3'd0, 32'h0,         32'h1234_5678, 1'b0);
    push_command(KIND_CNT_WRITE,  8'd159, 3'd0, 32'h0,         32'h7FFF_FFFF, 1'b0);
    push_command(KIND_BLK_ON,     8'd0,   3'd4, 32'hFFFF_FFFF, 32'h0,         1'b0);
    push_command(KIND_CNT_READ,   8'd159, 3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_BLK_TOGGLE, 8'd0,   3'd4, 32'h0000_00FF, 32'h0,         1'b0);
    push_command(KIND_BLK_TOGGLE, 8'd0,   3'd4, 32'h0000_01FF, 32'h0,         1'b0);
    push_command(KIND_BLK_TOGGLE, 8'd0,   3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_BLK_OFF,    8'd0,   3'd4, 32'hFFFF_0000, 32'h0,         1'b0);
    push_command(KIND_BLK_ON,     8'd0,   3'd5, 32'hFFFF_FFFF, 32'h0,         1'b0);
    push_command(KIND_BLK_TOGGLE, 8'd0,   3'd7, 32'hFFFF_FFFF, 32'h0,         1'b0);
    push_command(KIND_ACK,        8'd0,   3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_ACK,        8'd0,   3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_CLEAR,      8'd0,   3'd0, 32'h0,         32'h0,         1'b0);
    push_command(KIND_FIRST_UNUSED, 8'd5, 3'd1, 32'hFFFF_FFFF, 32'h0,         1'b0);
    push_command(KIND_LAST_UNUSED,  8'd5, 3'd1, 32'hFFFF_FFFF, 32'h0,         1'b0);
    push_command(KIND_BLK_OFF,    8'd0,   3'd0, 32'hFFFF_FFFF, 32'h0,         1'b1);
    while (n_real < RANDOM_COMMANDS) begin
      c = random_command();
      if (n_real % 150 == 149) c.hold = 1'b1;
      cmd_q.push_back(c);
      if (c.kind <= KIND_ACK) n_real++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (cmd_q.size() != 0 || start || n_done != n_issued);
    repeat (40) @(negedge clk);
    if (expected_q.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
